[rtl/tdcs_pkg.sv]
`timescale 1ns / 1ps
package tdcs_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TW = 13;
  localparam logic [TW-1:0] TIME_MAX = '1;

  localparam logic [2:0] POL_FCFS   = 3'd0;
  localparam logic [2:0] POL_SJF_NP = 3'd1;
  localparam logic [2:0] POL_SJF_P  = 3'd2;
  localparam logic [2:0] POL_PRI_NP = 3'd3;
  localparam logic [2:0] POL_PRI_P  = 3'd4;
  localparam logic [2:0] POL_RR     = 3'd5;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;

  localparam logic [2:0] POLICY_RST  = POL_FCFS;
  localparam logic [7:0] QUANTUM_RST = 8'd2;
  localparam logic [4:0] COUNT_RST   = 5'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic arr_step;
    logic preempt;
    logic sel_step;
    logic take;
    logic exec;
  } tdcs_cmd_t;

  typedef struct packed {
    logic arr_last;
    logic sel_last;
  } tdcs_stat_t;

  typedef struct packed {
    logic [3:0]    ran_slot;
    logic          idle;
    logic          finished;
    logic [TW-1:0] turnaround;
    logic [TW-1:0] waiting;
    logic          all_done;
    logic [TW-1:0] time_now;
  } tdcs_res_t;

endpackage

[rtl/tdcs_if.sv]
`timescale 1ns / 1ps
interface tdcs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] slot;
  logic [7:0] arrival;
  logic [7:0] burst;
  logic [3:0] prio;
  modport source (output valid, cmd, slot, arrival, burst, prio, input ready);
  modport sink (input valid, cmd, slot, arrival, burst, prio, output ready);
endinterface

interface tdcs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  ran_slot;
  logic        idle;
  logic        finished;
  logic [12:0] turnaround;
  logic [12:0] waiting;
  logic        all_done;
  logic [12:0] time_now;
  modport source (output valid, ran_slot, idle, finished, turnaround, waiting, all_done,
                  time_now, input ready);
  modport sink (input valid, ran_slot, idle, finished, turnaround, waiting, all_done,
                time_now, output ready);
endinterface

[rtl/tick_driven_cpu_scheduler_core.sv]
`timescale 1ns / 1ps
// Channel | Dir | Fields                                             | Transfer
// in_i    | in  | cmd, slot, arrival, burst, prio                    | valid & ready
// out_o   | out | ran_slot, idle, finished, turnaround, waiting,     | valid & ready
//         |     | all_done, time_now                                 |
// APB     | in  | policy @0x0, quantum @0x4, process_count @0x8      | psel&penable&pwrite
// A load goes straight to its result state; a tick sweeps the counted slots for arrivals,
// then checks preemption, sweeps the ready queue for selection, takes, executes and publishes.
// The next item is taken while a finished result waits in the output register.
// Reset is asynchronous, active low; tables hold garbage until loaded.
module tick_driven_cpu_scheduler_core import tdcs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdcs_in_if.sink     in_i,
  tdcs_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] policy_q;
  logic [7:0] quantum_q;
  logic [4:0] count_q;
  logic       out_valid_q;
  tdcs_res_t  out_q, res;
  tdcs_cmd_t  cmd;
  tdcs_stat_t stat;
  logic       publish, out_free, wr;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    case (paddr[3:2])
      REG_POLICY:  prdata = {29'd0, policy_q};
      REG_QUANTUM: prdata = {24'd0, quantum_q};
      REG_COUNT:   prdata = {27'd0, count_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RST;
      quantum_q <= QUANTUM_RST;
      count_q <= COUNT_RST;
    end else if (wr) begin
      case (paddr[3:2])
        REG_POLICY:  policy_q <= pwdata[2:0];
        REG_QUANTUM: quantum_q <= pwdata[7:0];
        REG_COUNT:   count_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (publish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) out_q <= res;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ran_slot   = out_q.ran_slot;
  assign out_o.idle       = out_q.idle;
  assign out_o.finished   = out_q.finished;
  assign out_o.turnaround = out_q.turnaround;
  assign out_o.waiting    = out_q.waiting;
  assign out_o.all_done   = out_q.all_done;
  assign out_o.time_now   = out_q.time_now;

  tdcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .publish_o  (publish),
    .cmd_o      (cmd)
  );

  tdcs_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .slot_i    (in_i.slot),
    .arrival_i (in_i.arrival),
    .burst_i   (in_i.burst),
    .prio_i    (in_i.prio),
    .policy_i  (policy_q),
    .quantum_i (quantum_q),
    .count_i   (count_q),
    .stat_o    (stat),
    .res_o     (res)
  );

endmodule

[rtl/tdcs_ctrl.sv]
`timescale 1ns / 1ps
module tdcs_ctrl import tdcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  input  logic       out_free_i,
  input  tdcs_stat_t stat_i,
  output logic       in_ready_o,
  output logic       publish_o,
  output tdcs_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARRIVE, ST_PREEMPT, ST_SELECT, ST_TAKE, ST_EXEC, ST_RESULT
  } state_e;

  state_e state_q;
  logic   acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign publish_o  = (state_q == ST_RESULT) && out_free_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = acc && (in_cmd_i == CMD_LOAD);
    cmd_o.tick_start = acc && (in_cmd_i == CMD_TICK);
    cmd_o.arr_step   = (state_q == ST_ARRIVE);
    cmd_o.preempt    = (state_q == ST_PREEMPT);
    cmd_o.sel_step   = (state_q == ST_SELECT);
    cmd_o.take       = (state_q == ST_TAKE);
    cmd_o.exec       = (state_q == ST_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (acc) state_q <= (in_cmd_i == CMD_LOAD) ? ST_RESULT : ST_ARRIVE;
        end
        ST_ARRIVE: begin
          if (stat_i.arr_last) state_q <= ST_PREEMPT;
        end
        ST_PREEMPT: state_q <= ST_SELECT;
        ST_SELECT: begin
          if (stat_i.sel_last) state_q <= ST_TAKE;
        end
        ST_TAKE: state_q <= ST_EXEC;
        ST_EXEC: state_q <= ST_RESULT;
        ST_RESULT: begin
          if (out_free_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/tdcs_dp.sv]
`timescale 1ns / 1ps
module tdcs_dp import tdcs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tdcs_cmd_t  cmd_i,
  input  logic [3:0] slot_i,
  input  logic [7:0] arrival_i,
  input  logic [7:0] burst_i,
  input  logic [3:0] prio_i,
  input  logic [2:0] policy_i,
  input  logic [7:0] quantum_i,
  input  logic [4:0] count_i,
  output tdcs_stat_t stat_o,
  output tdcs_res_t  res_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [7:0]    arr_q   [SLOTS];
  logic [7:0]    burst_q [SLOTS];
  logic [3:0]    prio_q  [SLOTS];
  logic [7:0]    rem_q   [SLOTS];
  logic [SW-1:0] order_q [SLOTS];
  logic [SLOTS-1:0] done_q, inq_q;
  logic [CW-1:0] qcnt_q, idx_q, best_pos_q;
  logic [7:0]    best_key_q, slice_q;
  logic          cur_valid_q, run_valid_q;
  logic [SW-1:0] cur_q, run_q;
  logic [TW-1:0] time_q;
  logic [3:0]    r_ran_q;
  logic          r_idle_q, r_fin_q;
  logic [TW-1:0] r_tat_q, r_wt_q, r_time_q;

  logic [2:0]    pol;
  logic          pre, rr;
  logic [CW-1:0] n;
  logic [SW-1:0] ii, push_slot, pick_slot, ld_slot;
  logic          ld_ok, arr_hit, pre_push, push_ok, take_np, exec_rm, rm_en;
  logic [7:0]    key, rem_new;
  logic          fin;
  logic [TW-1:0] tnext, tat, wt;
  logic [SLOTS-1:0] mask;

  always_comb begin
    pol = (policy_i > POL_RR) ? POL_FCFS : policy_i;
    pre = (pol == POL_SJF_P) || (pol == POL_PRI_P);
    rr  = (pol == POL_RR);
    n   = (int'(count_i) > SLOTS) ? CW'(SLOTS) : CW'(count_i);
    ii  = idx_q[SW-1:0];
    ld_slot = SW'(slot_i);
    ld_ok   = int'(slot_i) < SLOTS;
    pick_slot = order_q[best_pos_q[SW-1:0]];
    arr_hit = cmd_i.arr_step && (idx_q < n) && !done_q[ii] &&
              ({5'd0, arr_q[ii]} == time_q);
    pre_push = cmd_i.preempt && cur_valid_q && (pre || (rr && slice_q == 8'd0));
    push_slot = cmd_i.preempt ? cur_q : ii;
    push_ok = (arr_hit || pre_push) && (int'(qcnt_q) < SLOTS) && !inq_q[push_slot] &&
              !(arr_hit && cur_valid_q && cur_q == ii);
    take_np = cmd_i.take && !pre && !cur_valid_q && (qcnt_q != '0);
    rem_new = (rem_q[run_q] != 8'd0) ? rem_q[run_q] - 8'd1 : 8'd0;
    fin     = (rem_new == 8'd0);
    exec_rm = cmd_i.exec && run_valid_q && fin && pre;
    rm_en   = take_np || exec_rm;
    case (pol)
      POL_SJF_NP: key = burst_q[order_q[ii]];
      POL_SJF_P:  key = rem_q[order_q[ii]];
      POL_PRI_NP, POL_PRI_P: key = {4'd0, prio_q[order_q[ii]]};
      default:    key = 8'd0;
    endcase
    tnext = (time_q < TIME_MAX) ? time_q + 1'b1 : TIME_MAX;
    tat   = (tnext > {5'd0, arr_q[run_q]}) ? tnext - {5'd0, arr_q[run_q]} : '0;
    wt    = (tat > {5'd0, burst_q[run_q]}) ? tat - {5'd0, burst_q[run_q]} : '0;
    for (int i = 0; i < SLOTS; i++) mask[i] = (i < int'(n));
  end

  assign stat_o.arr_last = ({1'b0, idx_q} + 1'b1) >= {1'b0, n};
  assign stat_o.sel_last = ({1'b0, idx_q} + 1'b1) >= {1'b0, qcnt_q};

  assign res_o.ran_slot   = r_ran_q;
  assign res_o.idle       = r_idle_q;
  assign res_o.finished   = r_fin_q;
  assign res_o.turnaround = r_tat_q;
  assign res_o.waiting    = r_wt_q;
  assign res_o.time_now   = r_time_q;
  assign res_o.all_done   = &(done_q | ~mask);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (ld_ok) begin
        arr_q[ld_slot]   <= arrival_i;
        burst_q[ld_slot] <= burst_i;
        prio_q[ld_slot]  <= prio_i;
      end
      for (int i = 0; i < SLOTS; i++) begin
        rem_q[i] <= (ld_ok && ld_slot == SW'(i)) ? burst_i : burst_q[i];
      end
    end else begin
      if (push_ok) order_q[qcnt_q[SW-1:0]] <= push_slot;
      if (rm_en) begin
        for (int j = 0; j < SLOTS - 1; j++) begin
          if (j >= int'(best_pos_q)) order_q[j] <= order_q[j+1];
        end
      end
      if (cmd_i.exec && run_valid_q) rem_q[run_q] <= rem_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      inq_q <= '0;
      qcnt_q <= '0;
      idx_q <= '0;
      best_pos_q <= '0;
      best_key_q <= '0;
      slice_q <= '0;
      cur_valid_q <= 1'b0;
      run_valid_q <= 1'b0;
      cur_q <= '0;
      run_q <= '0;
      time_q <= '0;
      r_ran_q <= '0;
      r_idle_q <= 1'b1;
      r_fin_q <= 1'b0;
      r_tat_q <= '0;
      r_wt_q <= '0;
      r_time_q <= '0;
    end else if (cmd_i.load) begin
      done_q <= '0;
      inq_q <= '0;
      qcnt_q <= '0;
      slice_q <= '0;
      cur_valid_q <= 1'b0;
      cur_q <= '0;
      time_q <= '0;
      r_ran_q <= '0;
      r_idle_q <= 1'b1;
      r_fin_q <= 1'b0;
      r_tat_q <= '0;
      r_wt_q <= '0;
      r_time_q <= '0;
    end else begin
      if (cmd_i.tick_start || cmd_i.preempt) idx_q <= '0;
      if (cmd_i.arr_step) idx_q <= idx_q + 1'b1;
      if (pre_push) cur_valid_q <= 1'b0;
      if (push_ok) begin
        qcnt_q <= qcnt_q + 1'b1;
        inq_q[push_slot] <= 1'b1;
      end
      if (rm_en) begin
        qcnt_q <= qcnt_q - 1'b1;
        inq_q[pick_slot] <= 1'b0;
      end
      if (cmd_i.sel_step && (idx_q < qcnt_q)) begin
        if (idx_q == '0 || key < best_key_q) begin
          best_pos_q <= idx_q;
          best_key_q <= key;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.take) begin
        if (pre) begin
          run_valid_q <= (qcnt_q != '0);
          run_q <= pick_slot;
        end else if (take_np) begin
          cur_q <= pick_slot;
          cur_valid_q <= 1'b1;
          slice_q <= (quantum_i != 8'd0) ? quantum_i : 8'd1;
          run_valid_q <= 1'b1;
          run_q <= pick_slot;
        end else begin
          run_valid_q <= cur_valid_q;
          run_q <= cur_q;
        end
      end
      if (cmd_i.exec) begin
        time_q <= tnext;
        r_time_q <= tnext;
        r_ran_q <= run_valid_q ? 4'(run_q) : 4'd0;
        r_idle_q <= !run_valid_q;
        r_fin_q <= run_valid_q && fin;
        r_tat_q <= (run_valid_q && fin) ? tat : '0;
        r_wt_q <= (run_valid_q && fin) ? wt : '0;
        if (run_valid_q) begin
          if (slice_q != 8'd0) slice_q <= slice_q - 8'd1;
          if (fin) begin
            done_q[run_q] <= 1'b1;
            if (cur_valid_q && cur_q == run_q) cur_valid_q <= 1'b0;
          end
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(qcnt_q) <= SLOTS)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $countones(inq_q) == int'(qcnt_q))
    else $error("queued flags disagree with queue count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cur_valid_q && inq_q[cur_q]))
    else $error("running slot also queued");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (r_fin_q |-> !r_idle_q))
    else $error("finish reported on idle unit");

endmodule

[tb/tick_driven_cpu_scheduler_core_tb.sv]
`timescale 1ns / 1ps
module tick_driven_cpu_scheduler_core_tb import tdcs_pkg::*; ();

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1325;

  typedef struct packed {
    logic       cmd;
    logic [3:0] slot;
    logic [7:0] arrival;
    logic [7:0] burst;
    logic [3:0] prio;
  } sched_item_t;

  typedef struct packed {
    sched_item_t it;
    logic        chk;
    tdcs_res_t   r;
  } dir_row_t;

  localparam tdcs_res_t LOAD_RES = '{4'd0, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0};

  localparam dir_row_t DIR_TAB [25] = '{
    '{'{CMD_LOAD, 4'd15, 8'd255, 8'd255, 4'd15}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd5, 8'd0, 8'd1, 4'd0}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd6, 8'hAA, 8'h55, 4'd10}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd7, 8'h55, 8'hAA, 4'd5}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd8, 8'd1, 8'd128, 4'd8}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd9, 8'd128, 8'd127, 4'd7}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd10, 8'd7, 8'd3, 4'd1}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd11, 8'd9, 8'd4, 4'd2}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd12, 8'd4, 8'd5, 4'd3}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd13, 8'd2, 8'd2, 4'd12}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd14, 8'd6, 8'd6, 4'd14}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd0, 8'd0, 8'd3, 4'd4}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd1, 8'd0, 8'd1, 4'd2}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd2, 8'd1, 8'd2, 4'd9}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd3, 8'd3, 8'd1, 4'd0}, 1'b1, LOAD_RES},
    '{'{CMD_LOAD, 4'd4, 8'd2, 8'd4, 4'd15}, 1'b1, LOAD_RES},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd15, 8'd255, 8'd255, 4'd15}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 4'd0, 8'd0, 8'd1, 4'd0}, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  tdcs_in_if  in_if ();
  tdcs_out_if out_if ();

  tick_driven_cpu_scheduler_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scheduler state mirror
  logic [2:0] m_policy;
  logic [7:0] m_quantum;
  logic [4:0] m_count;
  logic [7:0] m_arr [NSLOT];
  logic [7:0] m_burst [NSLOT];
  logic [3:0] m_prio [NSLOT];
  logic [7:0] m_rem [NSLOT];
  logic       m_done [NSLOT];
  int         m_queue [$];
  logic       m_cur_vld;
  int         m_cur;
  int         m_slice;
  int         m_time;

  tdcs_res_t  sched_q [$];
  int         errors;
  int         cycles;
  int         burst_left;
  bit         hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tick_driven_cpu_scheduler_core_tb: FAIL");
      $finish;
    end
  end

  function automatic int counted_slots();
    return (m_count > NSLOT) ? NSLOT : int'(m_count);
  endfunction

  function automatic bit all_done_now();
    for (int i = 0; i < counted_slots(); i++) begin
      if (!m_done[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void enqueue(int s);
    foreach (m_queue[i]) begin
      if (m_queue[i] == s) return;
    end
    if (m_cur_vld && m_cur == s) return;
    if (m_queue.size() < NSLOT) m_queue.push_back(s);
  endfunction

  function automatic int sort_key(int s, int kind);
    if (kind == 1) return m_burst[s];
    if (kind == 2) return m_rem[s];
    return m_prio[s];
  endfunction

  function automatic int best_pos(int kind);
    int best, bk;
    best = 0;
    bk = sort_key(m_queue[0], kind);
    for (int i = 1; i < m_queue.size(); i++) begin
      if (sort_key(m_queue[i], kind) < bk) begin
        bk = sort_key(m_queue[i], kind);
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void restart_run();
    m_time = 0;
    m_queue.delete();
    m_cur_vld = 1'b0;
    m_cur = 0;
    m_slice = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_done[i] = 1'b0;
      m_rem[i] = m_burst[i];
    end
  endfunction

  function automatic tdcs_res_t schedule_unit(sched_item_t it);
    tdcs_res_t r;
    logic [2:0] pol;
    int run, tnext, tat, wt, pos, s;
    r = '0;
    if (it.cmd == CMD_LOAD) begin
      m_arr[it.slot] = it.arrival;
      m_burst[it.slot] = it.burst;
      m_prio[it.slot] = it.prio;
      restart_run();
      r.idle = 1'b1;
      r.all_done = all_done_now();
      return r;
    end
    pol = (m_policy > POL_RR) ? POL_FCFS : m_policy;
    run = -1;
    tat = 0;
    wt = 0;
    for (int i = 0; i < counted_slots(); i++) begin
      if (!m_done[i] && m_arr[i] == m_time) enqueue(i);
    end
    if ((pol == POL_SJF_P || pol == POL_PRI_P) && m_cur_vld) begin
      m_cur_vld = 1'b0;
      enqueue(m_cur);
    end
    if (pol == POL_RR && m_cur_vld && m_slice == 0) begin
      m_cur_vld = 1'b0;
      enqueue(m_cur);
    end
    if (pol == POL_SJF_P || pol == POL_PRI_P) begin
      if (m_queue.size() > 0) run = m_queue[best_pos(pol == POL_SJF_P ? 2 : 3)];
    end else begin
      if (!m_cur_vld && m_queue.size() > 0) begin
        pos = (pol == POL_SJF_NP) ? best_pos(1) : (pol == POL_PRI_NP) ? best_pos(3) : 0;
        m_cur = m_queue[pos];
        m_queue.delete(pos);
        m_cur_vld = 1'b1;
        m_slice = (m_quantum == 0) ? 1 : int'(m_quantum);
      end
      if (m_cur_vld) run = m_cur;
    end
    tnext = (m_time < int'(TIME_MAX)) ? m_time + 1 : int'(TIME_MAX);
    if (run >= 0) begin
      s = run;
      if (m_rem[s] > 0) m_rem[s]--;
      if (m_slice > 0) m_slice--;
      if (m_rem[s] == 0) begin
        r.finished = 1'b1;
        m_done[s] = 1'b1;
        tat = (tnext > m_arr[s]) ? tnext - m_arr[s] : 0;
        wt = (tat > m_burst[s]) ? tat - m_burst[s] : 0;
        foreach (m_queue[i]) begin
          if (m_queue[i] == s) begin
            m_queue.delete(i);
            break;
          end
        end
        if (m_cur_vld && m_cur == s) m_cur_vld = 1'b0;
      end
      r.ran_slot = s[3:0];
    end
    m_time = tnext;
    r.idle = (run < 0);
    r.turnaround = tat[12:0];
    r.waiting = wt[12:0];
    r.all_done = all_done_now();
    r.time_now = m_time[12:0];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    tdcs_res_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sched_q.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        w = sched_q.pop_front();
        if (out_if.ran_slot !== w.ran_slot) report("ran_slot", out_if.ran_slot, w.ran_slot);
        if (out_if.idle !== w.idle) report("idle", out_if.idle, w.idle);
        if (out_if.finished !== w.finished) report("finished", out_if.finished, w.finished);
        if (out_if.turnaround !== w.turnaround)
          report("turnaround", out_if.turnaround, w.turnaround);
        if (out_if.waiting !== w.waiting) report("waiting", out_if.waiting, w.waiting);
        if (out_if.all_done !== w.all_done) report("all_done", out_if.all_done, w.all_done);
        if (out_if.time_now !== w.time_now) report("time_now", out_if.time_now, w.time_now);
      end
    end
  end

  // receiver: alternate full-rate and choppy stretches, with one long hold-off
  initial begin
    int hold, mode_left;
    bit choppy;
    hold = 0;
    mode_left = 0;
    choppy = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        choppy = $urandom_range(0, 1);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  task automatic put_item(sched_item_t it, bit chk = 1'b0, tdcs_res_t typed = '0);
    tdcs_res_t p;
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.cmd <= it.cmd;
    in_if.slot <= it.slot;
    in_if.arrival <= it.arrival;
    in_if.burst <= it.burst;
    in_if.prio <= it.prio;
    do @(posedge clk_i); while (!in_if.ready);
    p = schedule_unit(it);
    sched_q.push_back(chk ? typed : p);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_POLICY: m_policy = val[2:0];
      REG_QUANTUM: m_quantum = val[7:0];
      default: m_count = val[4:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic sched_item_t tick_item();
    sched_item_t it;
    it = sched_item_t'(25'($urandom()));
    it.cmd = CMD_TICK;
    return it;
  endfunction

  initial begin
    sched_item_t it;
    int sent, n, ticks;
    bit hold_done;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.slot = '0;
    in_if.arrival = '0;
    in_if.burst = '0;
    in_if.prio = '0;
    m_policy = POLICY_RST;
    m_quantum = QUANTUM_RST;
    m_count = COUNT_RST;
    foreach (m_arr[i]) begin
      m_arr[i] = '0;
      m_burst[i] = '0;
      m_prio[i] = '0;
    end
    restart_run();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) put_item(DIR_TAB[i].it, DIR_TAB[i].chk, DIR_TAB[i].r);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0: apb_write(REG_POLICY, 32'($urandom_range(6, 7)));
        default: apb_write(REG_POLICY, 32'($urandom_range(POL_FCFS, POL_RR)));
      endcase
      case ($urandom_range(0, 5))
        0: apb_write(REG_QUANTUM, 32'd255);
        1: apb_write(REG_QUANTUM, 32'd1);
        2: apb_write(REG_QUANTUM, 32'd0);
        default: apb_write(REG_QUANTUM, 32'($urandom_range(1, 4)));
      endcase
      case ($urandom_range(0, 9))
        0: apb_write(REG_COUNT, 32'd16);
        1: apb_write(REG_COUNT, 32'd1);
        2: apb_write(REG_COUNT, 32'($urandom_range(0, 1) ? 0 : $urandom_range(17, 31)));
        default: apb_write(REG_COUNT, 32'($urandom_range(2, 8)));
      endcase
      if (sent > 200 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      n = counted_slots();
      // most runs start fresh; the rest carry on under the new settings
      if ($urandom_range(0, 4) != 0) begin
        for (int s = 0; s < n + $urandom_range(0, 2); s++) begin
          it = sched_item_t'(25'($urandom()));
          it.cmd = CMD_LOAD;
          if (s < n) it.slot = s[3:0];
          it.arrival = 8'($urandom_range(0, 12));
          it.burst = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 40))
                                                 : 8'($urandom_range(1, 6));
          if (n <= 2 && $urandom_range(0, 7) == 0) begin
            it.arrival = 8'($urandom_range(200, 255));
            it.burst = 8'($urandom_range(200, 255));
          end
          put_item(it);
          sent++;
        end
      end
      ticks = 0;
      while (ticks < 600 && sent < RANDOM_ITEMS &&
             (!all_done_now() || $urandom_range(0, 3) != 0)) begin
        put_item(tick_item());
        ticks++;
        sent++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("tick_driven_cpu_scheduler_core_tb: PASS");
    end else begin
      $display("tick_driven_cpu_scheduler_core_tb: FAIL");
    end
    $finish;
  end

endmodule
